// File: rtl/core/dhcm_pkg.sv
// Shared types, constants and a helper function of the dead/hot channel mask builder.
`timescale 1ns / 1ps
`default_nettype none

package dhcm_pkg;

  // Default geometry and count width.
  localparam int unsigned CHANNELS_PER_MODULE_DEF = 144;
  localparam int unsigned MODULES_DEF             = 420;
  localparam int unsigned RINGS_DEF               = 7;
  localparam int unsigned COUNT_WIDTH_DEF         = 32;

  // Field and register widths.
  localparam int unsigned OP_W       = 2;
  localparam int unsigned EV_W       = 32;
  localparam int unsigned MH_W       = 32;
  localparam int unsigned MF_W       = 24;
  localparam int unsigned SNS_W      = 21;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR      = 2'd0,
    OP_SET_EVENTS = 2'd1,
    OP_LOAD       = 2'd2,
    OP_QUERY      = 2'd3
  } op_e;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_HITS     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_FRACTION = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_S2N      = CFG_IDX_W'(2);

  // Ring geometry: modules per ring and the cumulative module count at each ring's end.
  localparam int unsigned RING_TABLE_SIZE = 7;
  localparam int unsigned RT_W            = 3;
  localparam int unsigned RING_MODULE_MAX = 78;
  localparam int unsigned RING_MODULES [RING_TABLE_SIZE] = '{42, 48, 54, 60, 66, 72, 78};
  localparam int unsigned RING_LAST_MODULE [RING_TABLE_SIZE] =
    '{42, 90, 144, 204, 270, 342, 420};

  // Channel count of a ring; rings beyond the table hold no channels.
  function automatic int unsigned ring_channels(int unsigned ring, int unsigned cpm);
    int unsigned n;
    n = 0;
    if (ring < RING_TABLE_SIZE) begin
      n = RING_MODULES[ring] * cpm;
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/dhcm_intf.sv
// Handshake interfaces for the input, result and configuration channels.
`timescale 1ns / 1ps
`default_nettype none

interface dhcm_in_if #(
  parameter int unsigned IDX_W   = 16,
  parameter int unsigned COUNT_W = dhcm_pkg::COUNT_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic [dhcm_pkg::OP_W-1:0]     operation;
  logic [IDX_W-1:0]              channel_index;
  logic [COUNT_W-1:0]            count_before;
  logic [COUNT_W-1:0]            count_window_a;
  logic [COUNT_W-1:0]            count_window_b;
  logic [COUNT_W-1:0]            count_after;
  logic [dhcm_pkg::EV_W-1:0]     event_total;

  modport source (
    output valid, operation, channel_index, count_before, count_window_a,
           count_window_b, count_after, event_total,
    input  ready
  );
  modport sink (
    input  valid, operation, channel_index, count_before, count_window_a,
           count_window_b, count_after, event_total,
    output ready
  );
endinterface

interface dhcm_res_if #(
  parameter int unsigned IDX_W = 16
);
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] queried_channel;
  logic             active;
  logic             enough_data;

  modport source (output valid, queried_channel, active, enough_data, input ready);
  modport sink   (input valid, queried_channel, active, enough_data, output ready);
endinterface

interface dhcm_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [dhcm_pkg::CFG_IDX_W-1:0]  index;
  logic [dhcm_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/dead_hot_channel_mask.sv
// Top level of the dead/hot channel mask builder: sequencer, ring sums and checks.
// Clear and set-event-count beats give no result.
// A load runs window sums, then the two products, then the compares,
// the channel memory write and the ring sum update; ready is low for the last two steps.
// A query runs to its result beat by channel memory read, products, compares, and a full result slot holds it;
// neither takes a new input beat until its sequence is done, since ready is high only in idle.
// Reset clears the state, result valid, configuration, event count and ring sums; the channel memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module dead_hot_channel_mask #(
  parameter int unsigned CHANNELS_PER_MODULE = dhcm_pkg::CHANNELS_PER_MODULE_DEF,
  parameter int unsigned MODULES             = dhcm_pkg::MODULES_DEF,
  parameter int unsigned RINGS               = dhcm_pkg::RINGS_DEF,
  parameter int unsigned COUNT_WIDTH         = dhcm_pkg::COUNT_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  dhcm_cfg_if.sink    cfg_i,
  dhcm_in_if.sink     in_i,
  dhcm_res_if.source  res_o
);

  localparam int unsigned TOTAL  = CHANNELS_PER_MODULE * MODULES;
  localparam int unsigned IDX_W  = (TOTAL > 1) ? $clog2(TOTAL) : 1;
  localparam int unsigned WIN_W  = COUNT_WIDTH + 1;
  localparam int unsigned SIG_W  = COUNT_WIDTH + 2;
  localparam int unsigned SUM_W  = SIG_W + IDX_W;
  localparam int unsigned SUM_LO = SUM_W / 2;
  localparam int unsigned SUM_HI = SUM_W - SUM_LO;
  localparam int unsigned RING_W = (RINGS > 1) ? $clog2(RINGS) : 1;
  localparam int unsigned RC_W   =
    $clog2(dhcm_pkg::RING_MODULE_MAX * CHANNELS_PER_MODULE + 1);
  localparam int unsigned RC_OUT = dhcm_pkg::ring_channels(RINGS - 1, CHANNELS_PER_MODULE);
  localparam int unsigned MF_W   = dhcm_pkg::MF_W;
  localparam int unsigned MH_W   = dhcm_pkg::MH_W;
  localparam int unsigned SNS_W  = dhcm_pkg::SNS_W;
  localparam int unsigned EV_W   = dhcm_pkg::EV_W;
  localparam int unsigned SP_W   = SNS_W + WIN_W + 1;
  localparam int unsigned S50_W  = SIG_W + 6;
  localparam int unsigned LR_W   = ((SIG_W + 16 > SP_W) ? SIG_W + 16 : SP_W) + 1;
  localparam int unsigned SK_W   = ((S50_W > EV_W + 1) ? S50_W : EV_W + 1) + 1;
  localparam int unsigned PL_W   = SIG_W + RC_W + 1;
  localparam int unsigned PH_W   = SUM_HI + MF_W + 1;
  localparam int unsigned PLO_W  = SUM_LO + MF_W;
  localparam int unsigned PE_W   = MH_W + RC_W;
  localparam int unsigned DC_W   =
    ((PL_W + 16 > PH_W + SUM_LO) ? PL_W + 16 : PH_W + SUM_LO) + 2;
  localparam int unsigned EN_W   = ((SUM_W + 8 > PE_W) ? SUM_W + 8 : PE_W) + 2;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LD1  = 3'd1;
  localparam logic [2:0] ST_LD2  = 3'd2;
  localparam logic [2:0] ST_QMUL = 3'd3;
  localparam logic [2:0] ST_QCMP = 3'd4;

  logic [2:0] state_q, state_d;

  // Configuration and global state.
  logic [MH_W-1:0]          mh_q;
  logic [MF_W-1:0]          mf_q;
  logic signed [SNS_W-1:0]  sns_q;
  logic [EV_W-1:0]          events_q;
  logic signed [SUM_W-1:0]  sum_q [RINGS];

  // Per-item working registers.
  logic [IDX_W-1:0]         idx_q;
  logic                     idx_ok_q;
  logic                     ring_ok_q;
  logic [RING_W-1:0]        ring_q;
  logic [WIN_W-1:0]         win_q;
  logic signed [SIG_W-1:0]  sig_q;
  logic signed [SP_W-1:0]   snsp_q;
  logic signed [S50_W-1:0]  sig50_q;
  logic signed [PL_W-1:0]   pl_q;
  logic signed [PH_W-1:0]   phi_q;
  logic [PLO_W-1:0]         plo_q;
  logic [PE_W-1:0]          pen_q;

  // Result register.
  logic                     out_valid_q;
  logic [IDX_W-1:0]         out_idx_q;
  logic                     out_active_q;
  logic                     out_enough_q;

  logic                     in_acc;
  logic                     cfg_acc;
  logic [WIN_W-1:0]         win_d;
  logic [WIN_W-1:0]         bg_d;
  logic signed [SIG_W-1:0]  sig_d;
  logic [31:0]              idx_ext;
  logic                     ring_found;
  logic [dhcm_pkg::RT_W-1:0] ring_tab;
  logic                     ring_ok_d;
  logic                     idx_ok_d;
  logic                     low_flag;
  logic                     add_ok;
  logic                     mem_we;
  logic                     mem_re;
  logic [SIG_W:0]           rd_data;
  logic signed [SIG_W-1:0]  rd_sig;
  logic [RC_W-1:0]          rc_sel;
  logic signed [SUM_W-1:0]  sum_sel;
  logic signed [DC_W-1:0]   dead_lhs;
  logic signed [DC_W-1:0]   dead_rhs;
  logic                     dead;
  logic                     enough;
  logic                     act;
  logic                     out_ld;

  assign in_acc      = in_i.valid && in_i.ready;
  assign cfg_acc     = cfg_i.valid && cfg_i.ready;
  assign in_i.ready  = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;

  // Window sums taken straight off the input beat.
  assign win_d = WIN_W'(in_i.count_window_a) + WIN_W'(in_i.count_window_b);
  assign bg_d  = WIN_W'(in_i.count_before) + WIN_W'(in_i.count_after);
  assign sig_d = $signed(SIG_W'(win_d)) - $signed(SIG_W'(bg_d));

  // A module lies in the first ring whose last module it does not pass; comparing the flat
  // index against the ring's last channel avoids dividing by the module size.
  assign idx_ext = 32'(in_i.channel_index);
  always_comb begin
    ring_found = 1'b0;
    ring_tab   = '0;
    for (int r = dhcm_pkg::RING_TABLE_SIZE - 1; r >= 0; r--) begin
      if (idx_ext < 32'(dhcm_pkg::RING_LAST_MODULE[r] * CHANNELS_PER_MODULE)) begin
        ring_found = 1'b1;
        ring_tab   = dhcm_pkg::RT_W'(r);
      end
    end
  end
  assign ring_ok_d = ring_found && (32'(ring_tab) < RINGS);
  assign idx_ok_d  = (idx_ext < TOTAL);

  // Load compares: signal * 2^16 against threshold * window sum, signal * 50 against events.
  assign low_flag = (LR_W'(sig_q) <<< 16) < LR_W'(snsp_q);
  assign add_ok   = SK_W'(sig50_q) <= $signed({{(SK_W - EV_W){1'b0}}, events_q});

  assign mem_we = (state_q == ST_LD2) && idx_ok_q;
  assign mem_re = in_acc && (in_i.operation == dhcm_pkg::OP_QUERY);

  dhcm_chan_mem #(
    .DEPTH (TOTAL),
    .AW    (IDX_W),
    .DW    (SIG_W + 1)
  ) u_chan_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (idx_q),
    .wdata_i ({low_flag, sig_q}),
    .re_i    (mem_re),
    .raddr_i (in_i.channel_index),
    .rdata_o (rd_data)
  );

  assign rd_sig  = $signed(rd_data[SIG_W-1:0]);
  assign rc_sel  = RC_W'(dhcm_pkg::ring_channels(32'(ring_q), CHANNELS_PER_MODULE));
  assign sum_sel = sum_q[ring_q];

  // Query compares: the ring sum product is rebuilt from its two partial products.
  assign dead_lhs = DC_W'(pl_q) <<< 16;
  assign dead_rhs = (DC_W'(phi_q) <<< SUM_LO) + $signed(DC_W'(plo_q));
  assign dead     = dead_lhs < dead_rhs;
  assign enough   = (EN_W'(sum_q[RINGS-1]) <<< 8) >= $signed(EN_W'(pen_q));
  assign act      = enough && idx_ok_q && ring_ok_q && !dead && !rd_data[SIG_W];
  assign out_ld   = (state_q == ST_QCMP) && (!out_valid_q || res_o.ready);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && in_i.operation == dhcm_pkg::OP_LOAD) begin
          state_d = ST_LD1;
        end else if (in_acc && in_i.operation == dhcm_pkg::OP_QUERY) begin
          state_d = ST_QMUL;
        end
      end
      ST_LD1:  state_d = ST_LD2;
      ST_LD2:  state_d = ST_IDLE;
      ST_QMUL: state_d = ST_QCMP;
      ST_QCMP: begin
        if (out_ld) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      mh_q        <= '0;
      mf_q        <= '0;
      sns_q       <= '0;
      events_q    <= '0;
      for (int r = 0; r < RINGS; r++) begin
        sum_q[r] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (out_ld) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_acc) begin
        case (cfg_i.index)
          dhcm_pkg::CFG_MIN_HITS:     mh_q  <= cfg_i.data[MH_W-1:0];
          dhcm_pkg::CFG_MIN_FRACTION: mf_q  <= cfg_i.data[MF_W-1:0];
          dhcm_pkg::CFG_MIN_S2N:      sns_q <= $signed(cfg_i.data[SNS_W-1:0]);
          default: ;
        endcase
      end
      if (in_acc && in_i.operation == dhcm_pkg::OP_SET_EVENTS) begin
        events_q <= in_i.event_total;
      end
      if (in_acc && in_i.operation == dhcm_pkg::OP_CLEAR) begin
        for (int r = 0; r < RINGS; r++) begin
          sum_q[r] <= '0;
        end
      end else if (state_q == ST_LD2 && idx_ok_q && ring_ok_q && add_ok) begin
        sum_q[ring_q] <= sum_sel + SUM_W'(sig_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      idx_q     <= in_i.channel_index;
      idx_ok_q  <= idx_ok_d;
      ring_ok_q <= ring_ok_d;
      ring_q    <= RING_W'(ring_tab);
      win_q     <= win_d;
      sig_q     <= sig_d;
    end
    if (state_q == ST_LD1) begin
      snsp_q  <= SP_W'(sns_q) * $signed({1'b0, win_q});
      // 50 = 32 + 16 + 2
      sig50_q <= (S50_W'(sig_q) <<< 5) + (S50_W'(sig_q) <<< 4) + (S50_W'(sig_q) <<< 1);
    end
    if (state_q == ST_QMUL) begin
      pl_q  <= PL_W'(rd_sig) * $signed({1'b0, rc_sel});
      phi_q <= PH_W'($signed(sum_sel[SUM_W-1:SUM_LO])) * $signed({1'b0, mf_q});
      plo_q <= PLO_W'(sum_sel[SUM_LO-1:0]) * PLO_W'(mf_q);
      pen_q <= PE_W'(mh_q) * PE_W'(RC_W'(RC_OUT));
    end
    if (out_ld) begin
      out_idx_q    <= idx_q;
      out_active_q <= act;
      out_enough_q <= enough;
    end
  end

  assign res_o.valid           = out_valid_q;
  assign res_o.queried_channel = out_idx_q;
  assign res_o.active          = out_active_q;
  assign res_o.enough_data     = out_enough_q;

  // A result that waits holds the sequencer in its compare step.
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_QCMP && out_valid_q && !res_o.ready) |=> (state_q == ST_QCMP))
    else $error("query sequencer left compare step while the result slot was full");

  a_clear_sums: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_i.operation == dhcm_pkg::OP_CLEAR) |=> (sum_q[RINGS-1] == '0))
    else $error("clear beat did not zero the outer ring sum");

  a_set_events: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_i.operation == dhcm_pkg::OP_SET_EVENTS) |=>
    (events_q == $past(in_i.event_total)))
    else $error("event count not taken from the set beat");

  a_write_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> ($past(state_q) == ST_LD1))
    else $error("channel memory written outside the load sequence");

  a_query_timing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_i.operation == dhcm_pkg::OP_QUERY) |=> ##1 (state_q == ST_QCMP))
    else $error("query did not reach the compare step two cycles after its beat");

endmodule

`default_nettype wire

// File: rtl/core/dhcm_chan_mem.sv
// Per-channel store of signal and low signal-to-noise flag, one write and one registered read.
`timescale 1ns / 1ps
`default_nettype none

module dhcm_chan_mem #(
  parameter int unsigned DEPTH = dhcm_pkg::CHANNELS_PER_MODULE_DEF * dhcm_pkg::MODULES_DEF,
  parameter int unsigned AW    = 16,
  parameter int unsigned DW    = dhcm_pkg::COUNT_WIDTH_DEF + 3
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire
